[hdl/rgb_to_hsv_convert_defines.svh]
// Assertion macros shared by the RGB to HSV converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RHC_CHECK_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_convert: check failed");

// Check that cons holds in the cycle after ante.
`define RHC_CHECK_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_convert: check failed");

`endif

[hdl/rhc_pkg.sv]
// Shared constants and types for the RGB to HSV converter.
// No dependencies; used by rgb_to_hsv_convert.
`default_nettype none

package rhc_pkg;

    localparam int CHANNEL_BITS_DEF = 8;

    // Hue is an angle in 1/64 degree units.
    localparam int HUE_BITS     = 15;
    localparam int HUE_QUO_BITS = 12;   // sector fraction never exceeds 3840

    localparam logic [HUE_BITS-1:0] UNITS_PER_SECTOR = 15'd3840;
    localparam logic [HUE_BITS-1:0] GREEN_OFFSET     = 15'd7680;
    localparam logic [HUE_BITS-1:0] BLUE_OFFSET      = 15'd15360;
    localparam logic [HUE_BITS-1:0] FULL_TURN        = 15'd23040;

    typedef logic [1:0] sector_t;

    localparam sector_t SECT_RED   = 2'd0;
    localparam sector_t SECT_GREEN = 2'd1;
    localparam sector_t SECT_BLUE  = 2'd2;

endpackage

`default_nettype wire

[hdl/rhc_div_pipe.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on nothing but its parameters; a tag word travels alongside.
`default_nettype none

module rhc_div_pipe #(
    parameter int CHANNEL_BITS = 8,
    parameter int QUO_BITS     = 12,
    parameter int TAG_BITS     = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [QUO_BITS+CHANNEL_BITS-1:0]  in_hue_dvd,
    input  wire logic [CHANNEL_BITS-1:0]           in_hue_dsr,
    input  wire logic [QUO_BITS+CHANNEL_BITS-1:0]  in_sat_dvd,
    input  wire logic [CHANNEL_BITS-1:0]           in_sat_dsr,
    input  wire logic [TAG_BITS-1:0]               in_tag,
    output logic                                   out_valid,
    output logic [QUO_BITS-1:0]                    out_hue_quo,
    output logic                                   out_hue_rem_nz,
    output logic [QUO_BITS-1:0]                    out_sat_quo,
    output logic [TAG_BITS-1:0]                    out_tag
);

    localparam int AW = QUO_BITS + CHANNEL_BITS;

    // Accumulator holds {partial remainder, dividend bits left, quotient bits}.
    function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                               input logic [CHANNEL_BITS-1:0] dsr);
        logic [CHANNEL_BITS:0]   trial;
        logic                    ge;
        logic [CHANNEL_BITS-1:0] rem;
        trial = acc[AW-1:QUO_BITS-1];
        ge    = (trial >= {1'b0, dsr});
        rem   = ge ? CHANNEL_BITS'(trial - {1'b0, dsr}) : trial[CHANNEL_BITS-1:0];
        return {rem, acc[QUO_BITS-2:0], ge};
    endfunction

    logic [QUO_BITS-1:0]      vld_reg;
    logic [QUO_BITS-1:0]      vld_next;
    logic [AW-1:0]            acc_h_reg  [QUO_BITS];
    logic [AW-1:0]            acc_h_next [QUO_BITS];
    logic [AW-1:0]            acc_s_reg  [QUO_BITS];
    logic [AW-1:0]            acc_s_next [QUO_BITS];
    logic [CHANNEL_BITS-1:0]  dsr_h_reg  [QUO_BITS];
    logic [CHANNEL_BITS-1:0]  dsr_h_next [QUO_BITS];
    logic [CHANNEL_BITS-1:0]  dsr_s_reg  [QUO_BITS];
    logic [CHANNEL_BITS-1:0]  dsr_s_next [QUO_BITS];
    logic [TAG_BITS-1:0]      tag_reg    [QUO_BITS];
    logic [TAG_BITS-1:0]      tag_next   [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_comb
            begin
                vld_next[k]   = in_valid;
                acc_h_next[k] = div_step(in_hue_dvd, in_hue_dsr);
                acc_s_next[k] = div_step(in_sat_dvd, in_sat_dsr);
                dsr_h_next[k] = in_hue_dsr;
                dsr_s_next[k] = in_sat_dsr;
                tag_next[k]   = in_tag;
            end
        end else begin : g_rest
            always_comb
            begin
                vld_next[k]   = vld_reg[k-1];
                acc_h_next[k] = div_step(acc_h_reg[k-1], dsr_h_reg[k-1]);
                acc_s_next[k] = div_step(acc_s_reg[k-1], dsr_s_reg[k-1]);
                dsr_h_next[k] = dsr_h_reg[k-1];
                dsr_s_next[k] = dsr_s_reg[k-1];
                tag_next[k]   = tag_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            acc_h_reg[k] <= acc_h_next[k];
            acc_s_reg[k] <= acc_s_next[k];
            dsr_h_reg[k] <= dsr_h_next[k];
            dsr_s_reg[k] <= dsr_s_next[k];
            tag_reg[k]   <= tag_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid      = vld_reg[QUO_BITS-1];
    assign out_hue_quo    = acc_h_reg[QUO_BITS-1][QUO_BITS-1:0];
    assign out_hue_rem_nz = |acc_h_reg[QUO_BITS-1][AW-1:QUO_BITS];
    assign out_sat_quo    = acc_s_reg[QUO_BITS-1][QUO_BITS-1:0];
    assign out_tag        = tag_reg[QUO_BITS-1];

endmodule

`default_nettype wire

[hdl/rgb_to_hsv_convert.sv]
// Top level of the RGB to HSV converter: channel sort, scaling, output assembly.
// Depends on rhc_pkg, rhc_div_pipe and rgb_to_hsv_convert_defines.svh.
`default_nettype none
`include "rgb_to_hsv_convert_defines.svh"

// Converts one pixel (red, green, blue) into hue, saturation and brightness.
//
// Input: a transfer happens at each rising edge where start is high and busy
// is low. busy is held low, so a pixel may be offered in every cycle.
// Output: done is high for exactly one cycle with hue, saturation and
// brightness of one pixel; results leave in the order pixels came in.
// The receiver cannot stall: each result is taken in its single done cycle.
//
// QB = max(12, CHANNEL_BITS) is the number of stages in the pipelined
// divider. Throughput: one pixel per cycle.
// Stages: channel sort and differences, constant scaling of the dividends,
// QB divider stages (one quotient bit each, hue and saturation side by
// side), then the hue sector offset and wrap.
//
// Reset (rst_n low, asynchronous) clears all valid bits; pixels in flight are
// dropped and no done pulse appears until new pixels arrive.
module rgb_to_hsv_convert #(
    parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [CHANNEL_BITS-1:0]       red,
    input  wire logic [CHANNEL_BITS-1:0]       green,
    input  wire logic [CHANNEL_BITS-1:0]       blue,
    output logic                               done,
    output logic [rhc_pkg::HUE_BITS-1:0]       hue,
    output logic [CHANNEL_BITS-1:0]            saturation,
    output logic [CHANNEL_BITS-1:0]            brightness
);

    // Divider stages: enough quotient bits for both the hue fraction
    // (at most 3840) and saturation (at most 2^CHANNEL_BITS - 1).
    localparam int QB  = (CHANNEL_BITS > rhc_pkg::HUE_QUO_BITS) ?
                         CHANNEL_BITS : rhc_pkg::HUE_QUO_BITS;
    localparam int DW  = QB + CHANNEL_BITS;
    localparam int TB  = CHANNEL_BITS + 4;   // {value, sector, negative, grey}
    localparam int LAT = QB + 3;

    // ------------------------------------------------------------------
    // Stage 1: pick the largest channel (red wins ties, then green), the
    // smallest, chroma, and the signed difference that sets the hue.
    // ------------------------------------------------------------------
    logic                    s1_valid_reg;
    logic [CHANNEL_BITS-1:0] s1_v_reg,    s1_v_next;
    logic [CHANNEL_BITS-1:0] s1_c_reg,    s1_c_next;
    rhc_pkg::sector_t        s1_sect_reg, s1_sect_next;
    logic                    s1_neg_reg,  s1_neg_next;
    logic [CHANNEL_BITS-1:0] s1_dmag_reg, s1_dmag_next;

    logic                    r_max;
    logic                    g_max;
    logic [CHANNEL_BITS-1:0] lo;
    logic [CHANNEL_BITS-1:0] rg_min;

    always_comb
    begin
        r_max  = (red >= green) && (red >= blue);
        g_max  = !r_max && (green >= blue);
        rg_min = (green < red) ? green : red;
        lo     = (blue < rg_min) ? blue : rg_min;

        if (r_max)
        begin
            s1_v_next    = red;
            s1_sect_next = rhc_pkg::SECT_RED;
            s1_neg_next  = (green < blue);
            s1_dmag_next = s1_neg_next ? (blue - green) : (green - blue);
        end
        else if (g_max)
        begin
            s1_v_next    = green;
            s1_sect_next = rhc_pkg::SECT_GREEN;
            s1_neg_next  = (blue < red);
            s1_dmag_next = s1_neg_next ? (red - blue) : (blue - red);
        end
        else
        begin
            s1_v_next    = blue;
            s1_sect_next = rhc_pkg::SECT_BLUE;
            s1_neg_next  = (red < green);
            s1_dmag_next = s1_neg_next ? (green - red) : (red - green);
        end

        s1_c_next = s1_v_next - lo;
    end

    // ------------------------------------------------------------------
    // Stage 2: scale the dividends. Hue fraction = 3840*|d| / chroma,
    // saturation = chroma*(2^N - 1) / value.
    // ------------------------------------------------------------------
    logic                    s2_valid_reg;
    logic [DW-1:0]           s2_hue_dvd_reg, s2_hue_dvd_next;
    logic [DW-1:0]           s2_sat_dvd_reg, s2_sat_dvd_next;
    logic [CHANNEL_BITS-1:0] s2_c_reg;
    logic [CHANNEL_BITS-1:0] s2_v_reg;
    logic [TB-1:0]           s2_tag_reg, s2_tag_next;

    always_comb
    begin
        s2_hue_dvd_next = DW'(s1_dmag_reg) * DW'(rhc_pkg::UNITS_PER_SECTOR);
        s2_sat_dvd_next = DW'({s1_c_reg, {CHANNEL_BITS{1'b0}}}) - DW'(s1_c_reg);
        s2_tag_next     = {s1_v_reg, s1_sect_reg, s1_neg_reg, (s1_c_reg == '0)};
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg       <= s1_v_next;
        s1_c_reg       <= s1_c_next;
        s1_sect_reg    <= s1_sect_next;
        s1_neg_reg     <= s1_neg_next;
        s1_dmag_reg    <= s1_dmag_next;
        s2_hue_dvd_reg <= s2_hue_dvd_next;
        s2_sat_dvd_reg <= s2_sat_dvd_next;
        s2_c_reg       <= s1_c_reg;
        s2_v_reg       <= s1_v_reg;
        s2_tag_reg     <= s2_tag_next;
    end

    // ------------------------------------------------------------------
    // Divider: both quotients advance one bit per stage; the tag follows.
    // A zero divisor only happens for a zero dividend; the result is
    // dropped at assembly through the grey and black flags.
    // ------------------------------------------------------------------
    logic                    dv_valid;
    logic [QB-1:0]           dv_hue_quo;
    logic                    dv_hue_rem_nz;
    logic [QB-1:0]           dv_sat_quo;
    logic [TB-1:0]           dv_tag;

    rhc_div_pipe #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .QUO_BITS     (QB),
        .TAG_BITS     (TB)
    ) u_div (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s2_valid_reg),
        .in_hue_dvd     (s2_hue_dvd_reg),
        .in_hue_dsr     (s2_c_reg),
        .in_sat_dvd     (s2_sat_dvd_reg),
        .in_sat_dsr     (s2_v_reg),
        .in_tag         (s2_tag_reg),
        .out_valid      (dv_valid),
        .out_hue_quo    (dv_hue_quo),
        .out_hue_rem_nz (dv_hue_rem_nz),
        .out_sat_quo    (dv_sat_quo),
        .out_tag        (dv_tag)
    );

    // ------------------------------------------------------------------
    // Output stage: add the sector offset. Green and blue sectors floor a
    // negative fraction (the offset keeps the numerator positive); the red
    // sector truncates toward zero and wraps a negative angle by 360 deg.
    // ------------------------------------------------------------------
    logic [CHANNEL_BITS-1:0]         f_v;
    rhc_pkg::sector_t                f_sect;
    logic                            f_neg;
    logic                            f_grey;
    logic [rhc_pkg::HUE_BITS-1:0]    frac;
    logic [rhc_pkg::HUE_BITS-1:0]    frac_floor;

    logic                            done_reg;
    logic [rhc_pkg::HUE_BITS-1:0]    hue_reg, hue_next;
    logic [CHANNEL_BITS-1:0]         sat_reg, sat_next;
    logic [CHANNEL_BITS-1:0]         bri_reg;

    always_comb
    begin
        f_v        = dv_tag[TB-1:4];
        f_sect     = dv_tag[3:2];
        f_neg      = dv_tag[1];
        f_grey     = dv_tag[0];
        frac       = rhc_pkg::HUE_BITS'(dv_hue_quo[rhc_pkg::HUE_QUO_BITS-1:0]);
        frac_floor = frac + rhc_pkg::HUE_BITS'(dv_hue_rem_nz);

        case (f_sect)
            rhc_pkg::SECT_RED:
            begin
                if (f_neg && (frac != '0))
                    hue_next = rhc_pkg::FULL_TURN - frac;
                else if (f_neg)
                    hue_next = '0;
                else
                    hue_next = frac;
            end
            rhc_pkg::SECT_GREEN:
            begin
                hue_next = f_neg ? (rhc_pkg::GREEN_OFFSET - frac_floor)
                                 : (rhc_pkg::GREEN_OFFSET + frac);
            end
            rhc_pkg::SECT_BLUE:
            begin
                hue_next = f_neg ? (rhc_pkg::BLUE_OFFSET - frac_floor)
                                 : (rhc_pkg::BLUE_OFFSET + frac);
            end
            default:
            begin
                hue_next = '0;
            end
        endcase

        if (f_grey)
            hue_next = '0;

        sat_next = (f_v == '0) ? '0 : dv_sat_quo[CHANNEL_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= hue_next;
        sat_reg <= sat_next;
        bri_reg <= f_v;
    end

    // Valid bits: advance one stage per cycle, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= dv_valid;
        end
    end

    // Every stage moves each cycle, so the block never pushes back.
    assign busy       = 1'b0;
    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `RHC_CHECK_NOW(a_done_has_source, clk, rst_n, done, $past(start, LAT))
    `RHC_CHECK_NEXT(a_stage_advance, clk, rst_n, s1_valid_reg, s2_valid_reg)
    `RHC_CHECK_NOW(a_hue_in_range, clk, rst_n, done, hue < rhc_pkg::FULL_TURN)
    `RHC_CHECK_NOW(a_black_is_grey, clk, rst_n, done && (brightness == '0), (saturation == '0) && (hue == '0))

endmodule

`default_nettype wire
